### src/bfh_pkg.sv
// Shared types and constants for the back/forward history stacks.
// No dependencies.
package bfh_pkg;

  localparam int unsigned HistoryDepthDef = 128;
  localparam int unsigned PageBitsDef     = 16;

  localparam int unsigned KindW   = 2;
  localparam int unsigned PageIdW = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned DepthW  = 8;

  localparam logic [KindW-1:0] KIND_VISIT   = 2'd0;
  localparam logic [KindW-1:0] KIND_BACK    = 2'd1;
  localparam logic [KindW-1:0] KIND_FORWARD = 2'd2;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_e;

endpackage

### src/bfh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfh_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/back_forward_history_stacks.sv
// Back/forward history: two stack RAMs, current-entry register and result register.
// Depends on bfh_pkg and bfh_ram.
//
// Each command beat has an accept cycle and a resolve state: in the accept cycle the
// top of the stack to be popped is read from its RAM; in the resolve state the read
// data is used, the push is written back and the result is loaded into the output
// register. The stack RAMs have registered read data, so no new command is accepted
// until the previous one is resolved. A new command is accepted while the previous
// result still waits in the output register; it then holds in the resolve cycle
// until the output register frees. No clearing pass is needed after reset.
module back_forward_history_stacks
  import bfh_pkg::*;
#(
  parameter int unsigned HistoryDepth = HistoryDepthDef,
  parameter int unsigned PageBits     = PageBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [PageIdW-1:0] page_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PageIdW-1:0] current_page_o,
  output logic [StatusW-1:0] status_o,
  output logic [DepthW-1:0]  back_depth_o,
  output logic [DepthW-1:0]  forward_depth_o
);

  localparam int unsigned AddrW = $clog2(HistoryDepth);
  localparam int unsigned CntW  = $clog2(HistoryDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(HistoryDepth);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  state_e state_q, state_d;

  logic [CntW-1:0]     back_cnt_q, back_cnt_d;
  logic [CntW-1:0]     fwd_cnt_q, fwd_cnt_d;
  logic [PageBits-1:0] cur_q, cur_d;

  logic [KindW-1:0]    cmd_kind_q;
  logic [PageBits-1:0] cmd_page_q;
  logic                pop_ok_q;

  logic                out_valid_q;
  logic [PageIdW-1:0]  out_page_q;
  status_e             out_status_q;
  logic [DepthW-1:0]   out_back_q, out_fwd_q;

  logic in_fire, out_free, resolve;
  logic back_re, fwd_re;
  logic [PageBits-1:0] back_rdata, fwd_rdata;
  logic back_we, fwd_we;
  logic [AddrW-1:0] back_waddr, fwd_waddr;
  logic [PageBits-1:0] back_wdata, fwd_wdata;
  status_e status_d;

  logic [PageBits+PageIdW-1:0] page_in_ext;
  logic [PageBits+PageIdW-1:0] page_out_ext;
  logic [CntW+DepthW-1:0]      back_ext, fwd_ext;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign resolve = (state_q == S_RESOLVE) && out_free;

  // Pop read is issued in the accept cycle.
  assign back_re = in_fire && (kind_i == KIND_BACK) && (back_cnt_q != '0);
  assign fwd_re  = in_fire && (kind_i == KIND_FORWARD) && (fwd_cnt_q != '0);

  bfh_ram #(.Width(PageBits), .Depth(HistoryDepth)) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (back_we),
    .waddr_i (back_waddr),
    .wdata_i (back_wdata),
    .re_i    (back_re),
    .raddr_i (AddrW'(back_cnt_q - CntOne)),
    .rdata_o (back_rdata)
  );

  bfh_ram #(.Width(PageBits), .Depth(HistoryDepth)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .re_i    (fwd_re),
    .raddr_i (AddrW'(fwd_cnt_q - CntOne)),
    .rdata_o (fwd_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_fire) state_d = S_RESOLVE;
      S_RESOLVE: if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Resolve: stack writes, counts, current entry and status
  always_comb begin
    back_cnt_d = back_cnt_q;
    fwd_cnt_d  = fwd_cnt_q;
    cur_d      = cur_q;
    status_d   = ST_OK;
    back_we    = 1'b0;
    fwd_we     = 1'b0;
    back_waddr = back_cnt_q[AddrW-1:0];
    fwd_waddr  = fwd_cnt_q[AddrW-1:0];
    back_wdata = cur_q;
    fwd_wdata  = cur_q;
    if (resolve) begin
      unique case (cmd_kind_q)
        KIND_VISIT: begin
          if (back_cnt_q == CntFull) begin
            status_d = ST_FULL;
          end else begin
            back_we    = 1'b1;
            back_cnt_d = back_cnt_q + CntOne;
          end
          fwd_cnt_d = '0;
          cur_d     = cmd_page_q;
        end
        KIND_BACK: begin
          if (!pop_ok_q) begin
            status_d = ST_EMPTY;
          end else begin
            back_cnt_d = back_cnt_q - CntOne;
            cur_d      = back_rdata;
            if (fwd_cnt_q == CntFull) begin
              status_d = ST_FULL;
            end else begin
              fwd_we    = 1'b1;
              fwd_cnt_d = fwd_cnt_q + CntOne;
            end
          end
        end
        KIND_FORWARD: begin
          if (!pop_ok_q) begin
            status_d = ST_EMPTY;
          end else begin
            fwd_cnt_d = fwd_cnt_q - CntOne;
            cur_d     = fwd_rdata;
            if (back_cnt_q == CntFull) begin
              status_d = ST_FULL;
            end else begin
              back_we    = 1'b1;
              back_cnt_d = back_cnt_q + CntOne;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign page_in_ext  = {{PageBits{1'b0}}, page_id_i};
  assign page_out_ext = {{PageIdW{1'b0}}, cur_d};
  assign back_ext     = {{DepthW{1'b0}}, back_cnt_d};
  assign fwd_ext      = {{DepthW{1'b0}}, fwd_cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      back_cnt_q  <= '0;
      fwd_cnt_q   <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      back_cnt_q <= back_cnt_d;
      fwd_cnt_q  <= fwd_cnt_d;
      cur_q      <= cur_d;
      if (resolve) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_kind_q <= kind_i;
      cmd_page_q <= page_in_ext[PageBits-1:0];
      pop_ok_q   <= back_re || fwd_re;
    end
    if (resolve) begin
      out_page_q   <= page_out_ext[PageIdW-1:0];
      out_status_q <= status_d;
      out_back_q   <= back_ext[DepthW-1:0];
      out_fwd_q    <= fwd_ext[DepthW-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_page_o  = out_page_q;
  assign status_o        = out_status_q;
  assign back_depth_o    = out_back_q;
  assign forward_depth_o = out_fwd_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_cnt_q <= CntFull) && (fwd_cnt_q <= CntFull))
    else $error("stack count beyond depth");

  a_empty_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resolve && (status_d == ST_EMPTY)) |=>
      (back_cnt_q == $past(back_cnt_q)) && (fwd_cnt_q == $past(fwd_cnt_q))
      && (cur_q == $past(cur_q)))
    else $error("empty pop changed state");

  a_visit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resolve && (cmd_kind_q == KIND_VISIT)) |=> (fwd_cnt_q == '0))
    else $error("visit left forward entries");

  a_read_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_re || fwd_re) |=> (state_q == S_RESOLVE) && !(back_we && fwd_we))
    else $error("stack read outside accept cycle");

endmodule

### tb/sv/bfh_checker.sv
// Checker for the back/forward history stacks: watches command and result beats, predicts
// each result from its own copy of both stacks and compares it field by field.
// Depends on bfh_pkg.
module bfh_checker
  import bfh_pkg::*;
#(
  parameter int unsigned HistoryDepth = HistoryDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  logic               cmd_ready_i,
  input  logic [KindW-1:0]   kind_i,
  input  logic [PageIdW-1:0] page_id_i,
  input  logic               view_valid_i,
  input  logic               view_ready_i,
  input  logic [PageIdW-1:0] current_page_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [DepthW-1:0]  back_depth_i,
  input  logic [DepthW-1:0]  forward_depth_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        cmds_o,
  output int unsigned        empty_pops_o,
  output int unsigned        full_pushes_o,
  output int unsigned        peak_back_o,
  output int unsigned        peak_fwd_o
);

  typedef struct packed {
    logic [PageIdW-1:0] page;
    status_e            status;
    logic [DepthW-1:0]  back_depth;
    logic [DepthW-1:0]  forward_depth;
  } history_view_t;

  logic [PageIdW-1:0] back_hist [HistoryDepth];
  logic [PageIdW-1:0] fwd_hist  [HistoryDepth];
  int unsigned        back_cnt;
  int unsigned        fwd_cnt;
  logic [PageIdW-1:0] cur_page;
  history_view_t      views_q [$];

  // Printing stops after a hundred faults; counting does not.
  task automatic report_fault(input string msg);
    fail_count_o++;
    if (fail_count_o <= 100) begin
      $display("[%0t] FAULT: %s", $time, msg);
    end
  endtask

  task automatic step_history(input logic [KindW-1:0] kind, input logic [PageIdW-1:0] page,
                              output history_view_t view);
    status_e            st;
    logic [PageIdW-1:0] top;
    st = ST_OK;
    case (kind)
      KIND_VISIT: begin
        if (back_cnt < HistoryDepth) begin
          back_hist[back_cnt] = cur_page;
          back_cnt++;
        end else begin
          st = ST_FULL;
        end
        cur_page = page;
        fwd_cnt  = 0;
      end
      KIND_BACK: begin
        if (back_cnt == 0) begin
          st = ST_EMPTY;
        end else begin
          back_cnt--;
          top = back_hist[back_cnt];
          if (fwd_cnt < HistoryDepth) begin
            fwd_hist[fwd_cnt] = cur_page;
            fwd_cnt++;
          end else begin
            st = ST_FULL;
          end
          cur_page = top;
        end
      end
      KIND_FORWARD: begin
        if (fwd_cnt == 0) begin
          st = ST_EMPTY;
        end else begin
          fwd_cnt--;
          top = fwd_hist[fwd_cnt];
          if (back_cnt < HistoryDepth) begin
            back_hist[back_cnt] = cur_page;
            back_cnt++;
          end else begin
            st = ST_FULL;
          end
          cur_page = top;
        end
      end
      default: ;  // unused kind: state untouched, status ok
    endcase
    if (st == ST_EMPTY) empty_pops_o++;
    if (st == ST_FULL) full_pushes_o++;
    view = '{cur_page, st, DepthW'(back_cnt), DepthW'(fwd_cnt)};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    history_view_t want;
    if (!rst_ni) begin
      back_cnt      = 0;
      fwd_cnt       = 0;
      cur_page      = '0;
      views_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      cmds_o        = 0;
      empty_pops_o  = 0;
      full_pushes_o = 0;
      peak_back_o   = 0;
      peak_fwd_o    = 0;
    end else begin
      // result first: a beat accepted now never belongs to a command accepted now
      if (view_valid_i && view_ready_i) begin
        if (views_q.size() == 0) begin
          report_fault("result beat with no command outstanding");
        end else begin
          want = views_q.pop_front();
          if (current_page_i !== want.page)
            report_fault($sformatf("current_page got %h want %h", current_page_i, want.page));
          if (status_i !== want.status)
            report_fault($sformatf("status got %0d want %0d", status_i, want.status));
          if (back_depth_i !== want.back_depth)
            report_fault($sformatf("back_depth got %0d want %0d",
                                   back_depth_i, want.back_depth));
          if (forward_depth_i !== want.forward_depth)
            report_fault($sformatf("forward_depth got %0d want %0d",
                                   forward_depth_i, want.forward_depth));
        end
      end
      if (cmd_valid_i && cmd_ready_i) begin
        step_history(kind_i, page_id_i, want);
        views_q.push_back(want);
        cmds_o++;
        if (back_cnt > peak_back_o) peak_back_o = back_cnt;
        if (fwd_cnt > peak_fwd_o) peak_fwd_o = fwd_cnt;
      end
      pending_o = views_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
// Top of the back/forward history testbench: drives command beats and the result channel
// with random gaps and stalls, and gives the verdict from the checker's fault count.
// Depends on bfh_pkg, back_forward_history_stacks and bfh_checker.
module tb;
  import bfh_pkg::*;

  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned NumCmds    = 2000;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldOff    = 400;
  localparam int unsigned HoldAt     = 600;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [KindW-1:0]   kind_i;
  logic [PageIdW-1:0] page_id_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [PageIdW-1:0] current_page_o;
  logic [StatusW-1:0] status_o;
  logic [DepthW-1:0]  back_depth_o;
  logic [DepthW-1:0]  forward_depth_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cmds;
  int unsigned empty_pops;
  int unsigned full_pushes;
  int unsigned peak_back;
  int unsigned peak_fwd;
  int unsigned sent;
  bit          tx_calm;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  back_forward_history_stacks u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .page_id_i       (page_id_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .current_page_o  (current_page_o),
    .status_o        (status_o),
    .back_depth_o    (back_depth_o),
    .forward_depth_o (forward_depth_o)
  );

  bfh_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (in_valid_i),
    .cmd_ready_i     (in_ready_o),
    .kind_i          (kind_i),
    .page_id_i       (page_id_i),
    .view_valid_i    (out_valid_o),
    .view_ready_i    (out_ready_i),
    .current_page_i  (current_page_o),
    .status_i        (status_o),
    .back_depth_i    (back_depth_o),
    .forward_depth_i (forward_depth_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .cmds_o          (cmds),
    .empty_pops_o    (empty_pops),
    .full_pushes_o   (full_pushes),
    .peak_back_o     (peak_back),
    .peak_fwd_o      (peak_fwd)
  );

  function automatic logic [PageIdW-1:0] draw_page();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PageIdW'($urandom);
    endcase
  endfunction

  // Called and returns at a falling edge; valid stays high across back-to-back beats.
  task automatic send_cmd(input logic [KindW-1:0] kind, input logic [PageIdW-1:0] page);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    page_id_i  <= page;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent++;
  endtask

  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    bit          rx_calm;
    taken       = 0;
    rx_calm     = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 8);
      // one long hold-off so the block backs up into its input
      if (taken == HoldAt) stall = HoldOff;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
      taken++;
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("Timeout: no beat for %0d cycles", StallLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned run;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    kind_i     = KIND_VISIT;
    page_id_i  = '0;
    sent       = 0;
    tx_calm    = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty pops, unused kind, home page as ordinary entry, extreme ids
    send_cmd(KIND_BACK, '0);
    send_cmd(KIND_FORWARD, '1);
    send_cmd(KIND_UNUSED, 16'h1234);
    send_cmd(KIND_VISIT, '0);
    send_cmd(KIND_VISIT, '1);
    send_cmd(KIND_VISIT, 16'h5A5A);
    send_cmd(KIND_VISIT, 16'hA5A5);
    send_cmd(KIND_BACK, '1);
    send_cmd(KIND_BACK, 16'h00FF);
    send_cmd(KIND_FORWARD, '0);
    send_cmd(KIND_UNUSED, '1);
    send_cmd(KIND_VISIT, 16'h8000);
    send_cmd(KIND_FORWARD, '0);
    tx_calm = 1'b1;
    send_cmd(KIND_BACK, '0);
    send_cmd(KIND_BACK, '0);
    send_cmd(KIND_BACK, '0);
    send_cmd(KIND_BACK, '0);
    send_cmd(KIND_BACK, '0);
    send_cmd(KIND_FORWARD, '0);
    send_cmd(KIND_FORWARD, '0);
    send_cmd(KIND_FORWARD, '0);
    send_cmd(KIND_FORWARD, '0);
    send_cmd(KIND_FORWARD, '0);
    send_cmd(KIND_VISIT, 16'h7FFF);

    // runs of one kind (some of mixed kinds) drive the stacks to full and back to empty
    while (sent < NumCmds) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      run = ($urandom_range(0, 6) == 0) ? HistoryDepthDef + $urandom_range(2, 12)
                                        : $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1, 2: repeat (run) send_cmd(KIND_VISIT, draw_page());
        3, 4:    repeat (run) send_cmd(KIND_BACK, draw_page());
        5, 6:    repeat (run) send_cmd(KIND_FORWARD, draw_page());
        default: repeat (run) send_cmd(KindW'($urandom_range(0, 3)), draw_page());
      endcase
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("Checked %0d commands: %0d empty pops, %0d full-stack drops", cmds, empty_pops,
             full_pushes);
    $display("Deepest back stack %0d, deepest forward stack %0d, of %0d entries", peak_back,
             peak_fwd, HistoryDepthDef);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
